@@ sv/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro samples on aclk; the first one is masked while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked while out of reset.
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ sv/sconv_pkg.sv @@
// Shared constants and types for the strided multichannel convolution block.
// Used by sconv_mac and the top level; no dependencies.
`timescale 1ns / 1ps

package sconv_pkg;

    // Default sizing of the stores.
    localparam int DEF_MAX_SIDE     = 32;
    localparam int DEF_MAX_KERNEL   = 11;
    localparam int DEF_MAX_FILTERS  = 16;
    localparam int DEF_MAX_CHANNELS = 128;

    // Datapath widths.
    localparam int DATA_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 48;

    // Register map, word index (byte address / 4).
    localparam logic [2:0] REG_SIDE   = 3'd0;
    localparam logic [2:0] REG_KERNEL = 3'd1;
    localparam logic [2:0] REG_STEP   = 3'd2;
    localparam logic [2:0] REG_FCOUNT = 3'd3;
    localparam logic [2:0] REG_CCOUNT = 3'd4;
    localparam logic [2:0] REG_RELU   = 3'd5;

    // Register reset values.
    localparam logic [5:0] RST_SIDE   = 6'd32;
    localparam logic [3:0] RST_KERNEL = 4'd3;
    localparam logic [2:0] RST_STEP   = 3'd1;
    localparam logic [4:0] RST_FCOUNT = 5'd1;
    localparam logic [7:0] RST_CCOUNT = 8'd1;
    localparam logic       RST_RELU   = 1'b1;

    // Input kinds carried in s_tuser.
    localparam logic ACT_WEIGHT = 1'b0;
    localparam logic ACT_PIXEL  = 1'b1;

    // Per-cycle control of the tap multiply-accumulate pipeline.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } tap_ctrl_t;

endpackage

@@ sv/sconv_mac.sv @@
// Weight store, line store and the tap multiply-accumulate pipeline.
// Depends on sconv_pkg for widths and tap_ctrl_t.
`timescale 1ns / 1ps

module sconv_mac #(
    parameter int MAX_SIDE    = sconv_pkg::DEF_MAX_SIDE,
    parameter int MAX_KERNEL  = sconv_pkg::DEF_MAX_KERNEL,
    parameter int MAX_FILTERS = sconv_pkg::DEF_MAX_FILTERS,
    localparam int CW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1,
    localparam int SLW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1,
    localparam int TAPS = MAX_KERNEL * MAX_KERNEL,
    localparam int TW   = (TAPS > 1) ? $clog2(TAPS) : 1,
    localparam int FIW  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1,
    localparam int WAW  = FIW + TW,
    localparam int LAW  = SLW + CW
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   w_we,
    input  logic [WAW-1:0]                         w_waddr,
    input  logic                                   lb_we,
    input  logic [LAW-1:0]                         lb_waddr,
    input  logic signed [sconv_pkg::DATA_W-1:0]    wr_data,
    input  sconv_pkg::tap_ctrl_t                   ctrl,
    input  logic [WAW-1:0]                         w_raddr,
    input  logic [LAW-1:0]                         lb_raddr,
    output logic signed [sconv_pkg::ACC_W-1:0]     acc,
    output logic                                   acc_done
);

    logic signed [sconv_pkg::DATA_W-1:0] weight_mem [2**WAW];
    logic signed [sconv_pkg::DATA_W-1:0] line_mem [2**LAW];

    logic signed [sconv_pkg::DATA_W-1:0] w_q_reg;
    logic signed [sconv_pkg::DATA_W-1:0] lb_q_reg;
    logic signed [sconv_pkg::PROD_W-1:0] prod_reg;
    logic signed [sconv_pkg::ACC_W-1:0]  acc_reg;
    sconv_pkg::tap_ctrl_t                rd_ctrl_reg;
    sconv_pkg::tap_ctrl_t                p_ctrl_reg;
    logic                                done_reg;
    logic signed [sconv_pkg::ACC_W-1:0]  prod_ext;

    always_ff @(posedge aclk) begin
        if (w_we) begin
            weight_mem[w_waddr] <= wr_data;
        end
        w_q_reg <= weight_mem[w_raddr];
    end

    always_ff @(posedge aclk) begin
        if (lb_we) begin
            line_mem[lb_waddr] <= wr_data;
        end
        lb_q_reg <= line_mem[lb_raddr];
    end

    assign prod_ext = {{(sconv_pkg::ACC_W - sconv_pkg::PROD_W){prod_reg[sconv_pkg::PROD_W-1]}},
                       prod_reg};

    always_ff @(posedge aclk) begin
        prod_reg <= w_q_reg * lb_q_reg;
        if (p_ctrl_reg.vld) begin
            acc_reg <= (p_ctrl_reg.first ? '0 : acc_reg) + prod_ext;
        end
        if (!aresetn) begin
            rd_ctrl_reg <= '0;
            p_ctrl_reg  <= '0;
            done_reg    <= 1'b0;
        end else begin
            rd_ctrl_reg <= ctrl;
            p_ctrl_reg  <= rd_ctrl_reg;
            done_reg    <= p_ctrl_reg.vld & p_ctrl_reg.last;
        end
    end

    assign acc      = acc_reg;
    assign acc_done = done_reg;

endmodule

@@ sv/strided_conv2d_multichannel_relu.sv @@
// Top level of the strided multichannel convolution: config port, stream counters,
// window sequencer and partial-sum memory. Depends on sconv_pkg and sconv_mac.
`timescale 1ns / 1ps

// Weight loads and pixels that complete no window on the stride grid never stall
// the input. A pixel that completes a window position keeps the input stalled
// while every filter's dot product is formed one tap per cycle through the single
// read port of the line store and the weight store, then added into the
// partial-sum memory. A result waits in the output register without stopping
// the next filter's taps; only its write-back step waits for that register to
// drain. After the last channel one result per filter comes out in filter order,
// tlast on the last filter, tuser set on the final position of the output map.
// Any register write restarts the pixel stream at row 0, column 0 of channel 0.
module strided_conv2d_multichannel_relu #(
    parameter int MAX_SIDE     = sconv_pkg::DEF_MAX_SIDE,
    parameter int MAX_KERNEL   = sconv_pkg::DEF_MAX_KERNEL,
    parameter int MAX_FILTERS  = sconv_pkg::DEF_MAX_FILTERS,
    parameter int MAX_CHANNELS = sconv_pkg::DEF_MAX_CHANNELS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // filter_index[3:0], tap_index[10:4], data_value[26:11]
    input  logic [0:0]  s_tuser,   // action[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // filter_id[3:0], out_row[8:4], out_col[13:9],
                                   // sum_value[61:14]
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // map_end[0]
);

    localparam int CW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int NW   = $clog2(MAX_SIDE + 1);
    localparam int KW   = $clog2(MAX_KERNEL + 1);
    localparam int SLW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int TAPS = MAX_KERNEL * MAX_KERNEL;
    localparam int TW   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FIW  = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
    localparam int FW   = $clog2(MAX_FILTERS + 1);
    localparam int CCW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CHW  = $clog2(MAX_CHANNELS + 1);
    localparam int PAW  = FIW + 2 * CW;
    localparam int AW   = sconv_pkg::ACC_W;

    typedef enum logic [1:0] {ST_IDLE, ST_TAPS, ST_DRAIN, ST_WB} state_t;

    // configuration registers
    logic [5:0] side_reg;
    logic [3:0] ksz_reg;
    logic [2:0] step_reg;
    logic [4:0] fcnt_reg;
    logic [7:0] ccnt_reg;
    logic       relu_reg;

    // effective sizes
    logic [NW-1:0]  s_eff;
    logic [KW-1:0]  k_eff;
    logic [2:0]     st_eff;
    logic [FW-1:0]  f_eff;
    logic [CHW-1:0] c_eff;

    // stream position
    logic [CW-1:0]  row_reg, row_next, col_reg, col_next;
    logic [CCW-1:0] ch_reg, ch_next;
    logic [SLW-1:0] slot_reg, slot_next;
    logic [2:0]     rph_reg, rph_next, cph_reg, cph_next;
    logic [CW-1:0]  orow_reg, orow_next, ocol_reg, ocol_next;

    // window being processed
    state_t         state_reg, state_next;
    logic [SLW-1:0] tslot_reg, tslot_next;
    logic [CW-1:0]  left_reg, left_next;
    logic [CW-1:0]  worow_reg, worow_next, wocol_reg, wocol_next;
    logic           first_reg, first_next, final_reg, final_next, mend_reg, mend_next;
    logic [KW-1:0]  ti_reg, ti_next, tj_reg, tj_next;
    logic [TW-1:0]  tap_reg, tap_next;
    logic [SLW-1:0] rslot_reg, rslot_next;
    logic [CW-1:0]  lcol_reg, lcol_next;
    logic [FIW-1:0] fi_reg, fi_next;
    logic           dot_rdy_reg, dot_rdy_next;

    // result register
    logic           m_vld_reg, m_vld_next;
    logic [3:0]     m_fid_reg;
    logic [4:0]     m_row_reg, m_col_reg;
    logic [AW-1:0]  m_sum_reg;
    logic           m_last_reg, m_mend_reg;
    logic           m_load;

    // input fields
    logic                              in_act;
    logic [3:0]                        in_fi;
    logic [6:0]                        in_ti;
    logic signed [sconv_pkg::DATA_W-1:0] in_data;

    logic        s_acc, px_acc, cfg_we;
    logic [2:0]  cfg_idx;
    logic        w_we;
    logic        col_last, row_last, col_hit, row_hit, hit, tap_last;
    sconv_pkg::tap_ctrl_t ctrl;
    logic [FIW+TW-1:0]    w_raddr;
    logic [SLW+CW-1:0]    lb_raddr;
    logic signed [AW-1:0] acc;
    logic                 acc_done;

    // partial sums
    logic [AW-1:0]  psum_mem [2**PAW];
    logic [AW-1:0]  psum_q_reg;
    logic [PAW-1:0] ps_addr;
    logic           ps_we;
    logic [AW-1:0]  ps_sum;

    assign in_act  = s_tuser[0];
    assign in_fi   = s_tdata[3:0];
    assign in_ti   = s_tdata[10:4];
    assign in_data = s_tdata[26:11];

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite && (cfg_idx <= sconv_pkg::REG_RELU);

    always_comb begin
        case (cfg_idx)
            sconv_pkg::REG_SIDE:   prdata = {26'd0, side_reg};
            sconv_pkg::REG_KERNEL: prdata = {28'd0, ksz_reg};
            sconv_pkg::REG_STEP:   prdata = {29'd0, step_reg};
            sconv_pkg::REG_FCOUNT: prdata = {27'd0, fcnt_reg};
            sconv_pkg::REG_CCOUNT: prdata = {24'd0, ccnt_reg};
            sconv_pkg::REG_RELU:   prdata = {31'd0, relu_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // saturate register values into the supported range
    always_comb begin
        if (side_reg == '0) begin
            s_eff = NW'(1);
        end else if (int'(side_reg) > MAX_SIDE) begin
            s_eff = NW'(MAX_SIDE);
        end else begin
            s_eff = NW'(side_reg);
        end
        if (ksz_reg == '0) begin
            k_eff = KW'(1);
        end else if (int'(ksz_reg) > MAX_KERNEL) begin
            k_eff = KW'(MAX_KERNEL);
        end else begin
            k_eff = KW'(ksz_reg);
        end
        if (int'(k_eff) > int'(s_eff)) begin
            k_eff = KW'(s_eff);
        end
        st_eff = (step_reg == '0) ? 3'd1 : step_reg;
        if (fcnt_reg == '0) begin
            f_eff = FW'(1);
        end else if (int'(fcnt_reg) > MAX_FILTERS) begin
            f_eff = FW'(MAX_FILTERS);
        end else begin
            f_eff = FW'(fcnt_reg);
        end
        if (ccnt_reg == '0) begin
            c_eff = CHW'(1);
        end else if (int'(ccnt_reg) > MAX_CHANNELS) begin
            c_eff = CHW'(MAX_CHANNELS);
        end else begin
            c_eff = CHW'(ccnt_reg);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign px_acc   = s_acc && (in_act == sconv_pkg::ACT_PIXEL);
    assign w_we     = s_acc && (in_act == sconv_pkg::ACT_WEIGHT)
                      && (int'(in_fi) < MAX_FILTERS) && (int'(in_ti) < TAPS);

    assign col_last = (int'(col_reg) + 1 >= int'(s_eff));
    assign row_last = (int'(row_reg) + 1 >= int'(s_eff));
    assign col_hit  = (int'(col_reg) + 1 >= int'(k_eff)) && (cph_reg == '0);
    assign row_hit  = (int'(row_reg) + 1 >= int'(k_eff)) && (rph_reg == '0);
    assign hit      = col_hit && row_hit;
    assign tap_last = (int'(ti_reg) + 1 == int'(k_eff)) && (int'(tj_reg) + 1 == int'(k_eff));

    assign ctrl.vld   = (state_reg == ST_TAPS);
    assign ctrl.first = (tap_reg == '0);
    assign ctrl.last  = tap_last;
    assign w_raddr    = {fi_reg, tap_reg};
    assign lb_raddr   = {rslot_reg, lcol_reg};

    assign ps_addr = {fi_reg, worow_reg, wocol_reg};
    assign ps_sum  = (first_reg ? '0 : psum_q_reg) + acc;
    assign ps_we   = (state_reg == ST_WB);
    assign m_load  = ps_we && final_reg;

    always_comb begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        ch_next      = ch_reg;
        slot_next    = slot_reg;
        rph_next     = rph_reg;
        cph_next     = cph_reg;
        orow_next    = orow_reg;
        ocol_next    = ocol_reg;
        tslot_next   = tslot_reg;
        left_next    = left_reg;
        worow_next   = worow_reg;
        wocol_next   = wocol_reg;
        first_next   = first_reg;
        final_next   = final_reg;
        mend_next    = mend_reg;
        ti_next      = ti_reg;
        tj_next      = tj_reg;
        tap_next     = tap_reg;
        rslot_next   = rslot_reg;
        lcol_next    = lcol_reg;
        fi_next      = fi_reg;
        dot_rdy_next = dot_rdy_reg;
        m_vld_next   = (m_vld_reg && m_tready) ? 1'b0 : m_vld_reg;

        case (state_reg)
            ST_IDLE: begin
                if (px_acc) begin
                    if (hit) begin
                        // latch the window and start the first filter
                        if (int'(slot_reg) >= int'(k_eff) - 1) begin
                            tslot_next = SLW'(int'(slot_reg) - int'(k_eff) + 1);
                        end else begin
                            tslot_next = SLW'(int'(slot_reg) + MAX_KERNEL - int'(k_eff) + 1);
                        end
                        rslot_next = tslot_next;
                        left_next  = CW'(int'(col_reg) + 1 - int'(k_eff));
                        lcol_next  = left_next;
                        worow_next = orow_reg;
                        wocol_next = ocol_reg;
                        first_next = (ch_reg == '0);
                        final_next = (int'(ch_reg) + 1 >= int'(c_eff));
                        mend_next  = (int'(row_reg) + int'(st_eff) >= int'(s_eff))
                                     && (int'(col_reg) + int'(st_eff) >= int'(s_eff));
                        ti_next    = '0;
                        tj_next    = '0;
                        tap_next   = '0;
                        fi_next    = '0;
                        state_next = ST_TAPS;
                    end
                    // advance the raster position
                    if (!col_last) begin
                        col_next = col_reg + 1'b1;
                        if (int'(col_reg) + 1 >= int'(k_eff)) begin
                            cph_next = (int'(cph_reg) + 1 == int'(st_eff)) ? 3'd0
                                                                           : cph_reg + 3'd1;
                        end else begin
                            cph_next = 3'd0;
                        end
                        if (col_hit) begin
                            ocol_next = ocol_reg + 1'b1;
                        end
                    end else begin
                        col_next  = '0;
                        cph_next  = 3'd0;
                        ocol_next = '0;
                        if (!row_last) begin
                            row_next  = row_reg + 1'b1;
                            slot_next = (int'(slot_reg) + 1 == MAX_KERNEL) ? '0
                                                                           : slot_reg + 1'b1;
                            if (int'(row_reg) + 1 >= int'(k_eff)) begin
                                rph_next = (int'(rph_reg) + 1 == int'(st_eff)) ? 3'd0
                                                                               : rph_reg + 3'd1;
                            end else begin
                                rph_next = 3'd0;
                            end
                            if (row_hit) begin
                                orow_next = orow_reg + 1'b1;
                            end
                        end else begin
                            row_next  = '0;
                            slot_next = '0;
                            rph_next  = 3'd0;
                            orow_next = '0;
                            ch_next   = (int'(ch_reg) + 1 >= int'(c_eff)) ? '0
                                                                          : ch_reg + 1'b1;
                        end
                    end
                end
            end
            ST_TAPS: begin
                tap_next = tap_reg + 1'b1;
                if (int'(tj_reg) + 1 == int'(k_eff)) begin
                    tj_next    = '0;
                    ti_next    = ti_reg + 1'b1;
                    rslot_next = (int'(rslot_reg) + 1 == MAX_KERNEL) ? '0 : rslot_reg + 1'b1;
                    lcol_next  = left_reg;
                end else begin
                    tj_next   = tj_reg + 1'b1;
                    lcol_next = lcol_reg + 1'b1;
                end
                if (tap_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (acc_done) begin
                    dot_rdy_next = 1'b1;
                end
                // the partial-sum read goes out here; hold if a result still blocks
                if ((dot_rdy_reg || acc_done) && (!final_reg || !m_vld_reg || m_tready)) begin
                    dot_rdy_next = 1'b0;
                    state_next   = ST_WB;
                end
            end
            ST_WB: begin
                if (m_load) begin
                    m_vld_next = 1'b1;
                end
                if (int'(fi_reg) + 1 >= int'(f_eff)) begin
                    state_next = ST_IDLE;
                end else begin
                    fi_next    = fi_reg + 1'b1;
                    ti_next    = '0;
                    tj_next    = '0;
                    tap_next   = '0;
                    rslot_next = tslot_reg;
                    lcol_next  = left_reg;
                    state_next = ST_TAPS;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a register write restarts the stream
        if (cfg_we) begin
            row_next  = '0;
            col_next  = '0;
            ch_next   = '0;
            slot_next = '0;
            rph_next  = 3'd0;
            cph_next  = 3'd0;
            orow_next = '0;
            ocol_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        tslot_reg <= tslot_next;
        left_reg  <= left_next;
        worow_reg <= worow_next;
        wocol_reg <= wocol_next;
        first_reg <= first_next;
        final_reg <= final_next;
        mend_reg  <= mend_next;
        ti_reg    <= ti_next;
        tj_reg    <= tj_next;
        tap_reg   <= tap_next;
        rslot_reg <= rslot_next;
        lcol_reg  <= lcol_next;
        fi_reg    <= fi_next;
        if (m_load) begin
            m_fid_reg  <= 4'(fi_reg);
            m_row_reg  <= 5'(worow_reg);
            m_col_reg  <= 5'(wocol_reg);
            m_sum_reg  <= (relu_reg && ps_sum[AW-1]) ? '0 : ps_sum;
            m_last_reg <= (int'(fi_reg) + 1 >= int'(f_eff));
            m_mend_reg <= mend_reg;
        end
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            ch_reg      <= '0;
            slot_reg    <= '0;
            rph_reg     <= 3'd0;
            cph_reg     <= 3'd0;
            orow_reg    <= '0;
            ocol_reg    <= '0;
            dot_rdy_reg <= 1'b0;
            m_vld_reg   <= 1'b0;
            side_reg    <= sconv_pkg::RST_SIDE;
            ksz_reg     <= sconv_pkg::RST_KERNEL;
            step_reg    <= sconv_pkg::RST_STEP;
            fcnt_reg    <= sconv_pkg::RST_FCOUNT;
            ccnt_reg    <= sconv_pkg::RST_CCOUNT;
            relu_reg    <= sconv_pkg::RST_RELU;
        end else begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            ch_reg      <= ch_next;
            slot_reg    <= slot_next;
            rph_reg     <= rph_next;
            cph_reg     <= cph_next;
            orow_reg    <= orow_next;
            ocol_reg    <= ocol_next;
            dot_rdy_reg <= dot_rdy_next;
            m_vld_reg   <= m_vld_next;
            if (cfg_we) begin
                case (cfg_idx)
                    sconv_pkg::REG_SIDE:   side_reg <= pwdata[5:0];
                    sconv_pkg::REG_KERNEL: ksz_reg  <= pwdata[3:0];
                    sconv_pkg::REG_STEP:   step_reg <= pwdata[2:0];
                    sconv_pkg::REG_FCOUNT: fcnt_reg <= pwdata[4:0];
                    sconv_pkg::REG_CCOUNT: ccnt_reg <= pwdata[7:0];
                    sconv_pkg::REG_RELU:   relu_reg <= pwdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ps_we) begin
            psum_mem[ps_addr] <= ps_sum;
        end
        psum_q_reg <= psum_mem[ps_addr];
    end

    sconv_mac #(
        .MAX_SIDE    (MAX_SIDE),
        .MAX_KERNEL  (MAX_KERNEL),
        .MAX_FILTERS (MAX_FILTERS)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .w_we     (w_we),
        .w_waddr  ({FIW'(in_fi), TW'(in_ti)}),
        .lb_we    (px_acc),
        .lb_waddr ({slot_reg, col_reg}),
        .wr_data  (in_data),
        .ctrl     (ctrl),
        .w_raddr  (w_raddr),
        .lb_raddr (lb_raddr),
        .acc      (acc),
        .acc_done (acc_done)
    );

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {2'b00, m_sum_reg, m_col_reg, m_row_reg, m_fid_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_mend_reg;

endmodule

@@ sv/sconv_chk.sv @@
// Port-level checker for strided_conv2d_multichannel_relu, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sconv_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast
);

    `CHK_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
    `CHK_ASSERT_ALWAYS(a_rst_quiet, !aresetn |=> !m_tvalid, "result valid right after reset")
    `CHK_ASSERT(a_weight_idle, s_tvalid && s_tready && !s_tuser[0] |=> s_tready, "weight load left the block busy")
    `CHK_ASSERT(a_busy_filters, m_tvalid && !m_tlast |-> !s_tready, "input taken before all filters of a position are out")

endmodule

bind strided_conv2d_multichannel_relu sconv_chk u_sconv_chk (.*);
